@@ rtl/v4n_pkg.sv @@
// ----------------------------------------------------------------------------
// v4n_pkg
// Shared types and constants for the 4-vector normalizer.
// ----------------------------------------------------------------------------
package v4n_pkg;

  localparam int COMP_W    = 32;               // Q16.16 component
  localparam int SQ_W      = 2 * COMP_W;       // one square
  localparam int SUM_W     = SQ_W + 2;         // sum of four squares, even width
  localparam int ROOT_W    = SUM_W / 2;        // 33-bit length
  localparam int SREM_W    = ROOT_W + 3;       // root remainder
  localparam int QUO_W     = 31;               // quotient bits 30..0
  localparam int FRAC_SH   = 30;               // Q2.30 output scaling
  localparam int DREM_W    = ROOT_W + 1;       // division remainder
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;

  typedef struct packed {
    logic [3:0]                  neg;
    logic [3:0][COMP_W-1:0]      mag_abs;
  } v4n_side_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] unit_x;
    logic signed [COMP_W-1:0] unit_y;
    logic signed [COMP_W-1:0] unit_z;
    logic signed [COMP_W-1:0] unit_w;
    logic [ROOT_W-1:0]        magnitude;
    logic                     is_zero;
  } v4n_res_t;

endpackage

@@ rtl/v4n_if.sv @@
// ----------------------------------------------------------------------------
// v4n_in_if / v4n_out_if
// Valid/ready channels for vector input and normalized result.
// ----------------------------------------------------------------------------
interface v4n_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_w;

  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface v4n_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic signed [31:0] unit_z;
  logic signed [31:0] unit_w;
  logic [32:0]        magnitude;
  logic               is_zero;

  modport source (output valid, unit_x, unit_y, unit_z, unit_w, magnitude, is_zero,
                  input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, magnitude, is_zero,
                  output ready);
endinterface

@@ rtl/v4n_square.sv @@
// ----------------------------------------------------------------------------
// v4n_square
// Two stages: absolute values and squares, then the exact sum of squares.
// ----------------------------------------------------------------------------
module v4n_square (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [3:0][v4n_pkg::COMP_W-1:0]     in_comp,
  output logic                                out_valid,
  output logic [v4n_pkg::SUM_W-1:0]           out_sum,
  output v4n_pkg::v4n_side_t                  out_side
);
  import v4n_pkg::*;

  logic                   v1_r, v2_r;
  logic [3:0][SQ_W-1:0]   sq_r;
  v4n_side_t              side1_r, side2_r;
  logic [SUM_W-1:0]       sum_r;
  v4n_side_t              side_nxt;
  logic [3:0][SQ_W-1:0]   sq_nxt;
  logic [SUM_W-1:0]       sum_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      side_nxt.neg[i]     = in_comp[i][COMP_W-1];
      // -(-2^31) wraps to 0x8000_0000, which is 2^31 read as unsigned
      side_nxt.mag_abs[i] = in_comp[i][COMP_W-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
      sq_nxt[i]           = SQ_W'(side_nxt.mag_abs[i]) * SQ_W'(side_nxt.mag_abs[i]);
    end
    sum_nxt = (SUM_W'(sq_r[0]) + SUM_W'(sq_r[1])) + (SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r    <= sq_nxt;
      side1_r <= side_nxt;
      sum_r   <= sum_nxt;
      side2_r <= side1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_sum   = sum_r;
  assign out_side  = side2_r;
endmodule

@@ rtl/v4n_sqrt.sv @@
// ----------------------------------------------------------------------------
// v4n_sqrt
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module v4n_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [v4n_pkg::SUM_W-1:0]     in_sum,
  input  v4n_pkg::v4n_side_t            in_side,
  output logic                          out_valid,
  output logic [v4n_pkg::ROOT_W-1:0]    out_root,
  output v4n_pkg::v4n_side_t            out_side
);
  import v4n_pkg::*;

  logic      [SQRT_STEPS:0]             vld_r;
  logic      [SUM_W-1:0]                rad_r  [SQRT_STEPS+1];
  logic      [SREM_W-1:0]               rem_r  [SQRT_STEPS+1];
  logic      [ROOT_W-1:0]               root_r [SQRT_STEPS+1];
  v4n_side_t                            side_r [SQRT_STEPS+1];

  always_comb begin
    vld_r[0]  = in_valid;
    rad_r[0]  = in_sum;
    rem_r[0]  = '0;
    root_r[0] = '0;
    side_r[0] = in_side;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [SREM_W-1:0] rem_sh;
    logic [SREM_W-1:0] trial;
    logic              take;

    always_comb begin
      rem_sh = {rem_r[k][SREM_W-3:0], rad_r[k][SUM_W-1 -: 2]};
      trial  = SREM_W'({root_r[k], 2'b01});
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else if (en) vld_r[k+1] <= vld_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= {rad_r[k][SUM_W-3:0], 2'b00};
        rem_r[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[k+1] <= {root_r[k][ROOT_W-2:0], take};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS];
  assign out_root  = root_r[SQRT_STEPS];
  assign out_side  = side_r[SQRT_STEPS];
endmodule

@@ rtl/v4n_div.sv @@
// ----------------------------------------------------------------------------
// v4n_div
// Four-lane restoring divider (one quotient bit per stage), then sign/zero fix.
// ----------------------------------------------------------------------------
module v4n_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [v4n_pkg::ROOT_W-1:0]    in_root,
  input  v4n_pkg::v4n_side_t            in_side,
  output logic                          out_valid,
  output v4n_pkg::v4n_res_t             out_res
);
  import v4n_pkg::*;

  logic [DIV_STEPS:0]                   vld_r;
  logic [ROOT_W-1:0]                    m_r    [DIV_STEPS+1];
  logic [3:0][DREM_W-1:0]               rem_r  [DIV_STEPS+1];
  logic [3:0][QUO_W-1:0]                q_r    [DIV_STEPS+1];
  logic [3:0]                           lsb_r  [DIV_STEPS+1];
  logic [3:0]                           neg_r  [DIV_STEPS+1];
  logic                                 fin_v_r;
  v4n_res_t                             fin_r, fin_nxt;

  // Dividend is mag_abs << 30; the quotient fits 31 bits, so the remainder
  // entering the first step is mag_abs >> 1 and its next bit is mag_abs[0].
  always_comb begin
    vld_r[0] = in_valid;
    m_r[0]   = in_root;
    neg_r[0] = in_side.neg;
    for (int i = 0; i < 4; i++) begin
      rem_r[0][i] = DREM_W'(in_side.mag_abs[i][COMP_W-1:1]);
      q_r[0][i]   = '0;
      lsb_r[0][i] = in_side.mag_abs[i][0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [3:0][DREM_W-1:0] rem_sh;
    logic [3:0]             take;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        rem_sh[i] = {rem_r[k][i][DREM_W-2:0], lsb_r[k][i]};
        take[i]   = (rem_sh[i] >= DREM_W'(m_r[k]));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else if (en) vld_r[k+1] <= vld_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k+1]   <= m_r[k];
        neg_r[k+1] <= neg_r[k];
        lsb_r[k+1] <= '0;
        for (int i = 0; i < 4; i++) begin
          rem_r[k+1][i] <= take[i] ? (rem_sh[i] - DREM_W'(m_r[k])) : rem_sh[i];
          q_r[k+1][i]   <= {q_r[k][i][QUO_W-2:0], take[i]};
        end
      end
    end
  end

  always_comb begin
    logic [3:0][COMP_W-1:0] u;
    logic                   zero;
    zero = (m_r[DIV_STEPS] == '0);
    for (int i = 0; i < 4; i++) begin
      u[i] = COMP_W'(q_r[DIV_STEPS][i]);
      if (neg_r[DIV_STEPS][i]) u[i] = ~u[i] + 1'b1;
      if (zero) u[i] = '0;
    end
    fin_nxt.unit_x    = u[0];
    fin_nxt.unit_y    = u[1];
    fin_nxt.unit_z    = u[2];
    fin_nxt.unit_w    = u[3];
    fin_nxt.magnitude = m_r[DIV_STEPS];
    fin_nxt.is_zero   = zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fin_v_r <= 1'b0;
    else if (en) fin_v_r <= vld_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) fin_r <= fin_nxt;
  end

  assign out_valid = fin_v_r;
  assign out_res   = fin_r;
endmodule

@@ rtl/vec4_normalize_top.sv @@
// ----------------------------------------------------------------------------
// vec4_normalize_top
// Normalizes a Q16.16 4-vector to Q2.30 unit components plus its length.
// ----------------------------------------------------------------------------
// Pipeline: 68 register stages (2 square/sum, 33 root steps, 31 quotient steps,
//   1 sign fix, 1 output register).
// One item per cycle unless stalled; every stage is a full pipeline register.
// A skid register behind the pipeline keeps in_if.ready registered.
// Reset (rst_n low, synchronous) clears all valid bits; no data is held.
module vec4_normalize_top (
  input  logic    clk,
  input  logic    rst_n,
  v4n_in_if.sink  in_if,
  v4n_out_if.source out_if
);
  import v4n_pkg::*;

  logic                   en;
  logic                   sq_v, rt_v, dv_v;
  logic [SUM_W-1:0]       sq_sum;
  v4n_side_t              sq_side, rt_side;
  logic [ROOT_W-1:0]      rt_root;
  v4n_res_t               dv_res;
  logic [3:0][COMP_W-1:0] comp;

  logic                   out_valid_r, skid_valid_r;
  v4n_res_t               out_r, skid_r;

  assign en          = !skid_valid_r;
  assign in_if.ready = en;
  assign comp        = {in_if.in_w, in_if.in_z, in_if.in_y, in_if.in_x};

  v4n_square u_square (
    .clk, .rst_n, .en,
    .in_valid (in_if.valid),
    .in_comp  (comp),
    .out_valid(sq_v),
    .out_sum  (sq_sum),
    .out_side (sq_side)
  );

  v4n_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (sq_v),
    .in_sum   (sq_sum),
    .in_side  (sq_side),
    .out_valid(rt_v),
    .out_root (rt_root),
    .out_side (rt_side)
  );

  v4n_div u_div (
    .clk, .rst_n, .en,
    .in_valid (rt_v),
    .in_root  (rt_root),
    .in_side  (rt_side),
    .out_valid(dv_v),
    .out_res  (dv_res)
  );

  // Output register plus skid: a stalled transfer parks the next result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_if.ready) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (!out_valid_r || out_if.ready) begin
        out_valid_r <= dv_v;
        out_r       <= dv_res;
      end else if (dv_v) begin
        skid_r       <= dv_res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.unit_x    = out_r.unit_x;
  assign out_if.unit_y    = out_r.unit_y;
  assign out_if.unit_z    = out_r.unit_z;
  assign out_if.unit_w    = out_r.unit_w;
  assign out_if.magnitude = out_r.magnitude;
  assign out_if.is_zero   = out_r.is_zero;
endmodule

@@ rtl/v4n_checker.sv @@
// ----------------------------------------------------------------------------
// v4n_checker
// Port-level checks on the normalizer result channel.
// ----------------------------------------------------------------------------
module v4n_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] unit_x,
  input logic signed [31:0] unit_y,
  input logic signed [31:0] unit_z,
  input logic signed [31:0] unit_w,
  input logic [32:0]        magnitude,
  input logic               is_zero
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(unit_x))
    else $error("stalled result changed");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_zero |-> magnitude == 33'd0 && unit_x == 32'sd0 &&
      unit_y == 32'sd0 && unit_z == 32'sd0 && unit_w == 32'sd0)
    else $error("zero vector gave nonzero fields");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_zero |-> magnitude != 33'd0)
    else $error("zero length without zero flag");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> unit_x <= 32'sd1073741824 && unit_x >= -32'sd1073741824 &&
      unit_w <= 32'sd1073741824 && unit_w >= -32'sd1073741824)
    else $error("unit component out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind vec4_normalize_top v4n_checker u_v4n_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .unit_x    (out_if.unit_x),
  .unit_y    (out_if.unit_y),
  .unit_z    (out_if.unit_z),
  .unit_w    (out_if.unit_w),
  .magnitude (out_if.magnitude),
  .is_zero   (out_if.is_zero)
);

@@ sim/vec4_normalize_top_test.sv @@
// ----------------------------------------------------------------------------
// vec4_normalize_top_test
// Drives Q16.16 4-vectors into the normalizer with random gaps on both sides
// and checks each unit vector and length against an in-bench computation or typed-in value.
// ----------------------------------------------------------------------------
module vec4_normalize_top_test;
  import v4n_pkg::*;

  localparam int NUM_RAND  = 1950;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 100;

  typedef struct {
    logic signed [31:0] x, y, z, w;
    logic               has_exp;
    v4n_res_t           exp_res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  v4n_in_if  in_if ();
  v4n_out_if out_if ();

  vec4_normalize_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  v4n_res_t unit_q[$];
  int       err_cnt = 0;
  int       idle_cyc = 0;
  bit       hold_off = 1'b0;
  bit       stim_done = 1'b0;
  vec_row_t dir_rows[$];

  // Truncated integer square root of a 66-bit sum, bit by bit.
  function automatic logic [32:0] isqrt_sum(input logic [65:0] v);
    logic [65:0] rem;
    logic [65:0] root;
    logic [65:0] bitv;
    rem  = v;
    root = '0;
    bitv = 66'd1 << 64;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[32:0];
  endfunction

  function automatic v4n_res_t normalize_vec(input logic signed [31:0] x, y, z, w);
    logic signed [31:0] comp [4];
    logic [32:0] mag_abs [4];
    logic [65:0] sum;
    logic [32:0] len;
    logic [63:0] quo;
    logic [31:0] unit [4];
    v4n_res_t r;
    comp[0] = x; comp[1] = y; comp[2] = z; comp[3] = w;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      mag_abs[i] = comp[i][31] ? (33'd0 - {comp[i][31], comp[i]}) : {1'b0, comp[i]};
      sum = sum + 66'(mag_abs[i]) * 66'(mag_abs[i]);
    end
    len = isqrt_sum(sum);
    for (int i = 0; i < 4; i++) begin
      if (len == 0) begin
        unit[i] = '0;
      end else begin
        quo = (64'(mag_abs[i]) << FRAC_SH) / 64'(len);
        unit[i] = comp[i][31] ? (32'd0 - quo[31:0]) : quo[31:0];
      end
    end
    r.unit_x = unit[0]; r.unit_y = unit[1]; r.unit_z = unit[2]; r.unit_w = unit[3];
    r.magnitude = len;
    r.is_zero = (len == 0);
    return r;
  endfunction

  function automatic v4n_res_t mk_res(input logic signed [31:0] ux, uy, uz, uw,
                                      input logic [32:0] m, input logic z);
    v4n_res_t r;
    r.unit_x = ux; r.unit_y = uy; r.unit_z = uz; r.unit_w = uw;
    r.magnitude = m; r.is_zero = z;
    return r;
  endfunction

  task automatic add_row(input logic signed [31:0] x, y, z, w,
                         input logic has_exp, input v4n_res_t r);
    vec_row_t row;
    row.x = x; row.y = y; row.z = z; row.w = w;
    row.has_exp = has_exp; row.exp_res = r;
    dir_rows.push_back(row);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3: return 32'($urandom_range(0, 131071)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vec(input logic signed [31:0] x, y, z, w);
    in_if.valid <= 1'b1;
    in_if.in_x  <= x;
    in_if.in_y  <= y;
    in_if.in_z  <= z;
    in_if.in_w  <= w;
    do @(posedge clk); while (!in_if.ready);
    unit_q.push_back(normalize_vec(x, y, z, w));
  endtask

  task automatic idle_in();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic force_stall();
    int stall_cyc;
    stall_cyc = 0;
    while (stall_cyc < 300) begin
      @(negedge clk);
      stall_cyc++;
    end
    hold_off = 1'b0;
  endtask

  // sender
  initial begin
    v4n_res_t none;
    logic signed [31:0] a, b, c, d;
    in_if.valid = 1'b0;
    in_if.in_x = '0; in_if.in_y = '0; in_if.in_z = '0; in_if.in_w = '0;
    none = '0;
    add_row(0, 0, 0, 0, 1'b1, mk_res(0, 0, 0, 0, 33'd0, 1'b1));
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
            mk_res(-(1 << 29), -(1 << 29), -(1 << 29), -(1 << 29), 33'h1_0000_0000, 1'b0));
    add_row(32'h0001_0000, 0, 0, 0, 1'b1, mk_res(1 << 30, 0, 0, 0, 33'h1_0000, 1'b0));
    add_row(0, 32'hffff_0000, 0, 0, 1'b1, mk_res(0, -(1 << 30), 0, 0, 33'h1_0000, 1'b0));
    add_row(0, 0, 1, 0, 1'b1, mk_res(0, 0, 1 << 30, 0, 33'd1, 1'b0));
    add_row(0, 0, 0, -1, 1'b1, mk_res(0, 0, 0, -(1 << 30), 33'd1, 1'b0));
    add_row(32'h7fff_ffff, 0, 0, 0, 1'b1,
            mk_res(1 << 30, 0, 0, 0, 33'h7fff_ffff, 1'b0));
    add_row(32'h8000_0000, 0, 0, 0, 1'b1,
            mk_res(-(1 << 30), 0, 0, 0, 33'h8000_0000, 1'b0));
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, none);
    add_row(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0, none);
    add_row(1, 1, 1, 1, 1'b0, none);
    add_row(-1, -1, -1, -1, 1'b0, none);
    add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, none);
    add_row(32'h0003_0000, 32'h0004_0000, 0, 0, 1'b0, none);
    add_row(1, 32'h7fff_ffff, -1, 32'h8000_0000, 1'b0, none);
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    foreach (dir_rows[i]) begin
      send_vec(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].w);
      // typed-in rows override the computed expectation
      if (dir_rows[i].has_exp) unit_q[$] = dir_rows[i].exp_res;
      idle_in();
    end
    for (int n = 0; n < NUM_RAND; n++) begin
      a = rand_comp(); b = rand_comp(); c = rand_comp(); d = rand_comp();
      if ($urandom_range(0, 15) == 0) begin
        b = 0; c = 0; d = 0;
      end
      send_vec(a, b, c, d);
      // long back-to-back stretch while the receiver is held off
      if (!hold_off) idle_in();
    end
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver; ready stays low for the whole hold-off window
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int g;
      if (hold_off) begin
        out_if.ready <= 1'b0;
        @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
        g = gap_len();
        if (g > 0) begin
          out_if.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  // one long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    repeat (400) @(posedge clk);
    hold_off = 1'b1;
    force_stall();
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      v4n_res_t got, want;
      got = mk_res(out_if.unit_x, out_if.unit_y, out_if.unit_z, out_if.unit_w,
                   out_if.magnitude, out_if.is_zero);
      if (unit_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = unit_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (unit_q.size() != 0 && idle_cyc < WDOG_MAX) @(posedge clk);
    if (idle_cyc < WDOG_MAX) repeat (DRAIN_CYC) @(posedge clk);
    if (idle_cyc >= WDOG_MAX || unit_q.size() != 0) begin
      $display("== FAIL ==");
    end else if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    wait (idle_cyc >= WDOG_MAX);
    $display("== FAIL ==");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/v4n_pkg.sv
rtl/v4n_if.sv
rtl/v4n_square.sv
rtl/v4n_sqrt.sv
rtl/v4n_div.sv
rtl/vec4_normalize_top.sv
rtl/v4n_checker.sv
sim/vec4_normalize_top_test.sv
